@@ rtl/core/sqmm_pkg.sv @@
// shared types and constants of the square matrix multiplier
// no dependencies; imported by the controller, the datapath and the top level
`default_nettype none

package sqmm_pkg;

	localparam int unsigned DEF_MAX_DIM    = 8;
	localparam int unsigned DEF_DATA_WIDTH = 32;
	localparam int unsigned CFG_W          = 4;
	localparam int unsigned IDX_FIELD_W    = 3;
	localparam int unsigned HALF_W         = 32;
	localparam int unsigned FIFO_DEPTH     = 2;
	localparam int unsigned FIFO_CNT_W     = 2;

	typedef enum logic {
		ST_LOAD,
		ST_COMPUTE
	} ctrl_state_t;

	typedef struct packed {
		logic wr_m;
		logic wr_n;
	} load_cmd_t;

	typedef struct packed {
		logic                   issue;
		logic                   first;
		logic                   last;
		logic                   final_entry;
		logic [IDX_FIELD_W-1:0] row;
		logic [IDX_FIELD_W-1:0] col;
	} step_cmd_t;

	typedef struct packed {
		logic                  entry_done;
		logic [FIFO_CNT_W-1:0] fifo_count;
	} dp_status_t;

endpackage

`default_nettype wire

@@ rtl/core/square_matrix_multiply.sv @@
// Square matrix multiplier C = M x N for signed n x n matrices, n set by the
// size register (0 acts as 1, above MAX_DIM acts as MAX_DIM). Elements
// arrive one per transfer, M row-major then N row-major, and are taken one per
// cycle while in_stall is low. The transfer that completes N starts the product:
// in_stall stays high while one multiply-accumulate unit works through n*n*n
// steps, one per cycle unless held back, and the entries of C leave row-major
// through a two-entry result queue, the last one marked. A stalled output holds
// back the multiply unit before a new entry once both queue entries are full or
// claimed by entries still in the pipeline. Sums wrap modulo 2^DATA_WIDTH.
// Writing the size register drops a partial load.
// depends on sqmm_pkg, sqmm_ctrl, sqmm_datapath
`default_nettype none

module square_matrix_multiply #(
	parameter int unsigned MAX_DIM    = sqmm_pkg::DEF_MAX_DIM,
	parameter int unsigned DATA_WIDTH = sqmm_pkg::DEF_DATA_WIDTH
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_wr_en,
	input  wire logic [sqmm_pkg::CFG_W-1:0]         cfg_wr_data,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic signed [DATA_WIDTH-1:0]       element_value,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic signed [DATA_WIDTH-1:0]            product_value,
	output logic [sqmm_pkg::IDX_FIELD_W-1:0]        result_row,
	output logic [sqmm_pkg::IDX_FIELD_W-1:0]        result_column,
	output logic                                    last_result
);
	import sqmm_pkg::*;

	localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM;
	localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	load_cmd_t         load;
	step_cmd_t         step;
	dp_status_t        status;
	logic [ADDR_W-1:0] wr_addr, a_addr, b_addr;

	sqmm_ctrl #(
		.MAX_DIM (MAX_DIM)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.status      (status),
		.load        (load),
		.wr_addr     (wr_addr),
		.step        (step),
		.a_addr      (a_addr),
		.b_addr      (b_addr)
	);

	sqmm_datapath #(
		.MAX_DIM    (MAX_DIM),
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.element_value (element_value),
		.load          (load),
		.wr_addr       (wr_addr),
		.step          (step),
		.a_addr        (a_addr),
		.b_addr        (b_addr),
		.status        (status),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.product_value (product_value),
		.result_row    (result_row),
		.result_column (result_column),
		.last_result   (last_result)
	);

endmodule

`default_nettype wire

@@ rtl/core/sqmm_ctrl.sv @@
// controller: size register, load sequencing and multiply-accumulate step issue
// depends on sqmm_pkg
`default_nettype none

module sqmm_ctrl #(
	parameter  int unsigned MAX_DIM = sqmm_pkg::DEF_MAX_DIM,
	localparam int unsigned DEPTH   = MAX_DIM * MAX_DIM,
	localparam int unsigned ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wr_en,
	input  wire logic [sqmm_pkg::CFG_W-1:0] cfg_wr_data,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire sqmm_pkg::dp_status_t       status,
	output sqmm_pkg::load_cmd_t             load,
	output logic [ADDR_W-1:0]               wr_addr,
	output sqmm_pkg::step_cmd_t             step,
	output logic [ADDR_W-1:0]               a_addr,
	output logic [ADDR_W-1:0]               b_addr
);
	import sqmm_pkg::*;

	localparam int unsigned IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);

	ctrl_state_t state_q, state_d;

	logic [DIM_W-1:0]      n_q;
	logic [ADDR_W-1:0]     elem_q;
	logic                  phase_q;
	logic [IDX_W-1:0]      k_q, c_q, r_q;
	logic [ADDR_W-1:0]     a_addr_q, b_addr_q, row_base_q;
	logic [FIFO_CNT_W-1:0] inflight_q;

	logic [DIM_W-1:0]   size_clamped;
	logic [DIM_W-1:0]   n_m1;
	logic [2*DIM_W-1:0] area_w;
	logic [ADDR_W-1:0]  area_m1;
	logic [ADDR_W-1:0]  n_a;
	logic               accept, elem_last, load_done;
	logic               last_k, last_c, last_r;
	logic [2:0]         slots;
	logic               can_issue;

	always_comb begin
		if (cfg_wr_data == '0) begin
			size_clamped = DIM_W'(1);
		end else if (cfg_wr_data > CFG_W'(MAX_DIM)) begin
			size_clamped = DIM_W'(MAX_DIM);
		end else begin
			size_clamped = DIM_W'(cfg_wr_data);
		end
	end

	assign n_m1    = n_q - DIM_W'(1);
	assign area_w  = {{DIM_W{1'b0}}, n_q} * {{DIM_W{1'b0}}, n_q};
	assign area_m1 = ADDR_W'(area_w - (2*DIM_W)'(1));
	assign n_a     = ADDR_W'(n_q);

	assign accept    = in_valid && (state_q == ST_LOAD);
	assign elem_last = (elem_q == area_m1);
	assign load_done = accept && phase_q && elem_last;

	assign last_k = (DIM_W'(k_q) == n_m1);
	assign last_c = (DIM_W'(c_q) == n_m1);
	assign last_r = (DIM_W'(r_q) == n_m1);

	// a new product entry needs a free result slot
	assign slots     = {1'b0, status.fifo_count} + {1'b0, inflight_q};
	assign can_issue = (state_q == ST_COMPUTE) && ((k_q != '0) || (slots < 3'(FIFO_DEPTH)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		in_stall         = 1'b1;
		load.wr_m        = accept && !phase_q;
		load.wr_n        = accept && phase_q;
		wr_addr          = elem_q;
		step.issue       = can_issue;
		step.first       = (k_q == '0);
		step.last        = last_k;
		step.final_entry = last_k && last_c && last_r;
		step.row         = IDX_FIELD_W'(r_q);
		step.col         = IDX_FIELD_W'(c_q);
		a_addr           = a_addr_q;
		b_addr           = b_addr_q;
		unique case (state_q)
			ST_LOAD: begin
				in_stall = 1'b0;
				if (load_done) begin
					state_d = ST_COMPUTE;
				end
			end
			ST_COMPUTE: begin
				if (can_issue && last_k && last_c && last_r) begin
					state_d = ST_LOAD;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q     <= DIM_W'(MAX_DIM);
			elem_q  <= '0;
			phase_q <= 1'b0;
		end else if (cfg_wr_en) begin
			n_q     <= size_clamped;
			elem_q  <= '0;
			phase_q <= 1'b0;
		end else if (accept) begin
			if (elem_last) begin
				elem_q  <= '0;
				phase_q <= !phase_q;
			end else begin
				elem_q <= elem_q + ADDR_W'(1);
			end
		end
	end

	// row, column and inner index walk with running store addresses
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q        <= '0;
			c_q        <= '0;
			r_q        <= '0;
			a_addr_q   <= '0;
			b_addr_q   <= '0;
			row_base_q <= '0;
		end else if (load_done) begin
			k_q        <= '0;
			c_q        <= '0;
			r_q        <= '0;
			a_addr_q   <= '0;
			b_addr_q   <= '0;
			row_base_q <= '0;
		end else if (can_issue) begin
			if (!last_k) begin
				k_q      <= k_q + IDX_W'(1);
				a_addr_q <= a_addr_q + ADDR_W'(1);
				b_addr_q <= b_addr_q + n_a;
			end else begin
				k_q <= '0;
				if (!last_c) begin
					c_q      <= c_q + IDX_W'(1);
					a_addr_q <= row_base_q;
					b_addr_q <= ADDR_W'(c_q) + ADDR_W'(1);
				end else begin
					c_q        <= '0;
					b_addr_q   <= '0;
					r_q        <= r_q + IDX_W'(1);
					row_base_q <= row_base_q + n_a;
					a_addr_q   <= row_base_q + n_a;
				end
			end
		end
	end

	// entries fully issued but not yet in the result queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			priority if ((can_issue && last_k) && !status.entry_done) begin
				inflight_q <= inflight_q + FIFO_CNT_W'(1);
			end else if (!(can_issue && last_k) && status.entry_done) begin
				inflight_q <= inflight_q - FIFO_CNT_W'(1);
			end else begin
				inflight_q <= inflight_q;
			end
		end
	end

	a_walk_restart: assert property (@(posedge clk) disable iff (!arst_n)
		load_done |=> (state_q == ST_COMPUTE && k_q == '0 && c_q == '0 && r_q == '0
			&& a_addr_q == '0 && b_addr_q == '0))
		else $error("index walk not restarted after load");

	a_inflight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(3'(inflight_q) + 3'(status.fifo_count)) <= 3'(FIFO_DEPTH + 1))
		else $error("too many product entries outstanding");

endmodule

`default_nettype wire

@@ rtl/core/sqmm_datapath.sv @@
// datapath: element stores, multiply-accumulate pipeline and result queue
// depends on sqmm_pkg; driven by sqmm_ctrl
`default_nettype none

module sqmm_datapath #(
	parameter  int unsigned MAX_DIM    = sqmm_pkg::DEF_MAX_DIM,
	parameter  int unsigned DATA_WIDTH = sqmm_pkg::DEF_DATA_WIDTH,
	localparam int unsigned DEPTH      = MAX_DIM * MAX_DIM,
	localparam int unsigned ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic signed [DATA_WIDTH-1:0]           element_value,
	input  wire sqmm_pkg::load_cmd_t                    load,
	input  wire logic [ADDR_W-1:0]                      wr_addr,
	input  wire sqmm_pkg::step_cmd_t                    step,
	input  wire logic [ADDR_W-1:0]                      a_addr,
	input  wire logic [ADDR_W-1:0]                      b_addr,
	output sqmm_pkg::dp_status_t                        status,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic signed [DATA_WIDTH-1:0]                product_value,
	output logic [sqmm_pkg::IDX_FIELD_W-1:0]            result_row,
	output logic [sqmm_pkg::IDX_FIELD_W-1:0]            result_column,
	output logic                                        last_result
);
	import sqmm_pkg::*;

	logic [DATA_WIDTH-1:0] mem_m_q [DEPTH];
	logic [DATA_WIDTH-1:0] mem_n_q [DEPTH];

	logic [DATA_WIDTH-1:0] a_s1, b_s1;
	logic [DATA_WIDTH-1:0] p_s3;
	step_cmd_t             st_s1, st_s2, st_s3;

	logic [DATA_WIDTH-1:0] acc_q;
	logic [DATA_WIDTH-1:0] acc_sum;

	logic [DATA_WIDTH-1:0]  fifo_val_q  [FIFO_DEPTH];
	logic [IDX_FIELD_W-1:0] fifo_row_q  [FIFO_DEPTH];
	logic [IDX_FIELD_W-1:0] fifo_col_q  [FIFO_DEPTH];
	logic                   fifo_last_q [FIFO_DEPTH];
	logic                   wr_ptr_q, rd_ptr_q;
	logic [FIFO_CNT_W-1:0]  count_q;
	logic                   push, pop;

	always_ff @(posedge clk) begin
		if (load.wr_m) begin
			mem_m_q[wr_addr] <= element_value;
		end
		if (load.wr_n) begin
			mem_n_q[wr_addr] <= element_value;
		end
		if (step.issue) begin
			a_s1 <= mem_m_q[a_addr];
			b_s1 <= mem_n_q[b_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s1 <= '0;
			st_s2 <= '0;
			st_s3 <= '0;
		end else begin
			st_s1 <= step;
			st_s2 <= st_s1;
			st_s3 <= st_s2;
		end
	end

	generate
		if (DATA_WIDTH <= HALF_W) begin : g_narrow
			logic [DATA_WIDTH-1:0] p_s2;

			always_ff @(posedge clk) begin
				p_s2 <= a_s1 * b_s1;
				p_s3 <= p_s2;
			end
		end else begin : g_wide
			localparam int unsigned HI_W = DATA_WIDTH - HALF_W;

			logic [2*HALF_W-1:0] ll_s2;
			logic [HI_W-1:0]     lh_s2, hl_s2;
			logic [HALF_W-1:0]   lh_full, hl_full;
			logic [HI_W-1:0]     cross_sum;

			// low word product plus the two cross terms, high by high drops out
			assign lh_full   = a_s1[HALF_W-1:0] * HALF_W'(b_s1[DATA_WIDTH-1:HALF_W]);
			assign hl_full   = HALF_W'(a_s1[DATA_WIDTH-1:HALF_W]) * b_s1[HALF_W-1:0];
			assign cross_sum = lh_s2 + hl_s2;

			always_ff @(posedge clk) begin
				ll_s2 <= {{HALF_W{1'b0}}, a_s1[HALF_W-1:0]} * {{HALF_W{1'b0}}, b_s1[HALF_W-1:0]};
				lh_s2 <= lh_full[HI_W-1:0];
				hl_s2 <= hl_full[HI_W-1:0];
				p_s3  <= ll_s2[DATA_WIDTH-1:0] + {cross_sum, {HALF_W{1'b0}}};
			end
		end
	endgenerate

	assign acc_sum = st_s3.first ? p_s3 : acc_q + p_s3;

	always_ff @(posedge clk) begin
		if (st_s3.issue) begin
			acc_q <= acc_sum;
		end
	end

	assign push = st_s3.issue && st_s3.last;
	assign pop  = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_val_q[wr_ptr_q]  <= acc_sum;
			fifo_row_q[wr_ptr_q]  <= st_s3.row;
			fifo_col_q[wr_ptr_q]  <= st_s3.col;
			fifo_last_q[wr_ptr_q] <= st_s3.final_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			priority if (push && !pop) begin
				count_q <= count_q + FIFO_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - FIFO_CNT_W'(1);
			end else begin
				count_q <= count_q;
			end
		end
	end

	assign out_valid     = (count_q != '0);
	assign product_value = fifo_val_q[rd_ptr_q];
	assign result_row    = fifo_row_q[rd_ptr_q];
	assign result_column = fifo_col_q[rd_ptr_q];
	assign last_result   = fifo_last_q[rd_ptr_q];

	assign status.entry_done = push;
	assign status.fifo_count = count_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < FIFO_CNT_W'(FIFO_DEPTH) || pop))
		else $error("result queue overflow");

	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> out_valid)
		else $error("finished entry not presented");

endmodule

`default_nettype wire

@@ tb/sv/square_matrix_multiply_test.sv @@
// self-checking testbench for square_matrix_multiply: directed and random matrix loads,
// each product entry compared with an in-bench model of C = M x N
// depends on sqmm_pkg and square_matrix_multiply
`timescale 1ns / 100ps

module square_matrix_multiply_test;
	import sqmm_pkg::*;

	localparam int unsigned DW            = DEF_DATA_WIDTH;
	localparam int unsigned STORE_DEPTH   = DEF_MAX_DIM * DEF_MAX_DIM;
	localparam int unsigned RANDOM_ITEMS  = 360;
	localparam int unsigned QUIET_ITEMS   = 60;
	localparam int unsigned SETTLE_CYCLES = 12;
	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned SCRIPT_LEN    = 28;

	typedef enum logic {
		STEP_SIZE,
		STEP_ELEMENT
	} step_kind_t;

	typedef struct {
		step_kind_t    kind;
		logic [DW-1:0] value;
		logic          typed;
		logic [DW-1:0] product;
	} directed_step_t;

	typedef struct packed {
		logic [DW-1:0]          product;
		logic [IDX_FIELD_W-1:0] row;
		logic [IDX_FIELD_W-1:0] col;
		logic                   last;
	} product_entry_t;

	typedef struct packed {
		logic          typed;
		logic [DW-1:0] product;
	} element_tag_t;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_wr_en;
	logic [CFG_W-1:0]              cfg_wr_data;
	logic                          in_valid;
	logic                          in_stall;
	logic signed [DW-1:0]          element_value;
	logic                          out_valid;
	logic                          out_stall;
	logic signed [DW-1:0]          product_value;
	logic [IDX_FIELD_W-1:0]        result_row;
	logic [IDX_FIELD_W-1:0]        result_column;
	logic                          last_result;

	// model state
	logic [DW-1:0]    m_elems [STORE_DEPTH];
	logic [DW-1:0]    n_elems [STORE_DEPTH];
	int unsigned      loaded = 0;
	logic [CFG_W-1:0] size_reg = CFG_W'(DEF_MAX_DIM);

	product_entry_t pending_products[$];
	element_tag_t   element_tags[$];
	int unsigned    failures = 0;
	int unsigned    items_sent = 0;
	int unsigned    cycle_count = 0;
	logic           quiet = 1'b0;

	directed_step_t directed_steps [SCRIPT_LEN] = '{
		'{STEP_SIZE,    32'h0000_0000, 1'b0, 32'h0000_0000},
		'{STEP_ELEMENT, 32'h0000_0003, 1'b0, 32'h0000_0000},
		'{STEP_ELEMENT, 32'hffff_fffb, 1'b1, 32'hffff_fff1},
		'{STEP_SIZE,    32'h0000_0001, 1'b0, 32'h0000_0000},
		'{STEP_ELEMENT, 32'h7fff_ffff, 1'b0, 32'h0000_0000},
		'{STEP_ELEMENT, 32'h7fff_ffff, 1'b1, 32'h0000_0001},
		'{STEP_ELEMENT, 32'h8000_0000, 1'b0, 32'h0000_0000},
		'{STEP_ELEMENT, 32'h8000_0000, 1'b1, 32'h0000_0000},
		'{STEP_ELEMENT, 32'h8000_0000, 1'b0, 32'h0000_0000},
		'{STEP_ELEMENT, 32'h0000_0001, 1'b1, 32'h8000_0000},
		'{STEP_ELEMENT, 32'hffff_ffff, 1'b0, 32'h0000_0000},
		'{STEP_ELEMENT, 32'hffff_ffff, 1'b1, 32'h0000_0001},
		'{STEP_SIZE,    32'h0000_0002, 1'b0, 32'h0000_0000},
		'{STEP_ELEMENT, 32'h0000_0011, 1'b0, 32'h0000_0000},
		'{STEP_ELEMENT, 32'h0000_0022, 1'b0, 32'h0000_0000},
		'{STEP_ELEMENT, 32'h0000_0033, 1'b0, 32'h0000_0000},
		// size write drops the partial load
		'{STEP_SIZE,    32'h0000_0001, 1'b0, 32'h0000_0000},
		'{STEP_ELEMENT, 32'h0000_0000, 1'b0, 32'h0000_0000},
		'{STEP_ELEMENT, 32'h0000_3039, 1'b1, 32'h0000_0000},
		'{STEP_SIZE,    32'h0000_0002, 1'b0, 32'h0000_0000},
		'{STEP_ELEMENT, 32'h0000_0001, 1'b0, 32'h0000_0000},
		'{STEP_ELEMENT, 32'hffff_ffff, 1'b0, 32'h0000_0000},
		'{STEP_ELEMENT, 32'h7fff_ffff, 1'b0, 32'h0000_0000},
		'{STEP_ELEMENT, 32'h8000_0000, 1'b0, 32'h0000_0000},
		'{STEP_ELEMENT, 32'h0000_0002, 1'b0, 32'h0000_0000},
		'{STEP_ELEMENT, 32'h0000_0003, 1'b0, 32'h0000_0000},
		'{STEP_ELEMENT, 32'hffff_fffc, 1'b0, 32'h0000_0000},
		'{STEP_ELEMENT, 32'h0000_0005, 1'b0, 32'h0000_0000}
	};

	square_matrix_multiply uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.element_value (element_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.product_value (product_value),
		.result_row    (result_row),
		.result_column (result_column),
		.last_result   (last_result)
	);

	always #10 clk = ~clk;

	function automatic int unsigned dim_of(input logic [CFG_W-1:0] code);
		int unsigned n;
		n = code;
		if (n == 0) n = 1;
		if (n > DEF_MAX_DIM) n = DEF_MAX_DIM;
		return n;
	endfunction

	// stores one element; the one that completes N queues every entry of C
	function automatic int unsigned take_element(input logic [DW-1:0] v);
		int unsigned    n;
		int unsigned    area;
		logic [DW-1:0]  acc;
		product_entry_t entry;
		n = dim_of(size_reg);
		area = n * n;
		if (loaded < area) begin
			m_elems[loaded] = v;
			loaded++;
			return 0;
		end
		n_elems[loaded - area] = v;
		loaded++;
		if (loaded < 2 * area) return 0;
		loaded = 0;
		for (int unsigned r = 0; r < n; r++) begin
			for (int unsigned c = 0; c < n; c++) begin
				acc = '0;
				for (int unsigned k = 0; k < n; k++) begin
					acc = acc + m_elems[r * n + k] * n_elems[k * n + c];
				end
				entry.product = acc;
				entry.row = r[IDX_FIELD_W-1:0];
				entry.col = c[IDX_FIELD_W-1:0];
				entry.last = (r == n - 1) && (c == n - 1);
				pending_products.push_back(entry);
			end
		end
		return area;
	endfunction

	function automatic logic [DW-1:0] random_element();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return '0;
			4, 5: return DW'($urandom_range(0, 16)) - DW'(8);
			default: return DW'($urandom);
		endcase
	endfunction

	// waits until every expected entry is out and the block has settled
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending_products.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_size(input logic [CFG_W-1:0] code);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= code;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic send_element(input logic [DW-1:0] v, input logic typed,
			input logic [DW-1:0] product);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			element_value <= DW'($urandom);
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		element_tags.push_back('{typed, product});
		in_valid <= 1'b1;
		element_value <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
		if (items_sent + QUIET_ITEMS >= RANDOM_ITEMS) quiet = 1'b1;
	endtask

	// transfer observation, prediction and checking
	always @(posedge clk) begin : observe
		element_tag_t   tag;
		product_entry_t entry;
		if (arst_n) begin
			if (cfg_wr_en) begin
				size_reg = cfg_wr_data;
				loaded = 0;
			end
			if (in_valid && !in_stall) begin
				tag = element_tags.pop_front();
				if (take_element(element_value) != 0 && tag.typed) begin
					entry = pending_products.pop_back();
					entry.product = tag.product;
					pending_products.push_back(entry);
				end
			end
			if (out_valid && !out_stall) begin
				if (pending_products.size() == 0) begin
					$error("unexpected product entry row %0d column %0d value %0d",
						result_row, result_column, product_value);
					failures++;
				end else begin
					entry = pending_products.pop_front();
					if (product_value !== entry.product) begin
						$error("product_value: expected %0d, got %0d",
							$signed(entry.product), product_value);
						failures++;
					end
					if (result_row !== entry.row) begin
						$error("result_row: expected %0d, got %0d", entry.row, result_row);
						failures++;
					end
					if (result_column !== entry.col) begin
						$error("result_column: expected %0d, got %0d", entry.col,
							result_column);
						failures++;
					end
					if (last_result !== entry.last) begin
						$error("last_result: expected %0d, got %0d", entry.last,
							last_result);
						failures++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 9) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		int unsigned      dim;
		int unsigned      area;
		int unsigned      products;
		int unsigned      phase;
		logic [CFG_W-1:0] size_code;
		logic             broken;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		element_value = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < SCRIPT_LEN; i++) begin
			if (directed_steps[i].kind == STEP_SIZE)
				write_size(directed_steps[i].value[CFG_W-1:0]);
			else
				send_element(directed_steps[i].value, directed_steps[i].typed,
					directed_steps[i].product);
		end

		items_sent = 0;
		phase = 0;
		while (items_sent < RANDOM_ITEMS) begin
			size_code = (phase == 0) ? CFG_W'(15) : CFG_W'($urandom_range(0, 7));
			write_size(size_code);
			dim = dim_of(size_code);
			area = dim * dim;
			products = $urandom_range(1, 3);
			broken = 1'b0;
			for (int p = 0; p < products && !broken && items_sent < RANDOM_ITEMS; p++) begin
				if (phase != 0 && $urandom_range(0, 7) == 0) begin
					// partial load, dropped by the next size write
					broken = 1'b1;
					repeat ($urandom_range(1, 2 * area - 1))
						send_element(random_element(), 1'b0, '0);
				end else begin
					for (int e = 0; e < 2 * area && items_sent < RANDOM_ITEMS; e++)
						send_element(random_element(), 1'b0, '0);
				end
			end
			phase++;
		end

		wait_idle();
		repeat (4 * SETTLE_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/sqmm_pkg.sv
rtl/core/sqmm_ctrl.sv
rtl/core/sqmm_datapath.sv
rtl/core/square_matrix_multiply.sv
tb/sv/square_matrix_multiply_test.sv
